/* sv/skpf_pkg.sv */
// Shared types and constants for the scalar Kalman position filter.
`default_nettype none

package skpf_pkg;

    localparam int PIX_W   = 16;
    localparam int VAR_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FIRST_Q   = 3'd0;
    localparam t_cfg_idx CFG_STEADY_Q  = 3'd1;
    localparam t_cfg_idx CFG_MEAS_R    = 3'd2;
    localparam t_cfg_idx CFG_START_VAR = 3'd3;
    localparam t_cfg_idx CFG_START_X   = 3'd4;
    localparam t_cfg_idx CFG_START_Y   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_DONE,
        S_OUT
    } t_state;

    // Per-item phase strobes shared by the lanes and the variance unit.
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic commit;
    } t_step_ctl;

endpackage

`default_nettype wire

/* sv/scalar_kalman_position_filter.sv */
// Top level of the two-lane scalar Kalman position filter.
//
// Input channel (s_axis): one beat per measured point, tdata = {meas_y, meas_x}.
// Output channel (m_axis): one beat per point, tdata = {filt_y, filt_x}, the
// filtered estimates truncated toward zero to whole pixels.
// Configuration: write i_cfg_wdata to register i_cfg_idx while i_cfg_wr_en is
// high; write only while the block is idle.
// Each item passes S_PREP, the restoring gain divider in S_DIV, the shift-add
// multiplies of both lanes and of the variance side by side in S_MUL, the
// commit in S_DONE and the output latch in S_OUT. Items are taken one at a
// time, only in S_IDLE; a new item is accepted
// while the previous result still waits in the output register.
// Reset restores the register defaults and clears the first-step flag; the
// first item loads the estimates and variance from the start registers.
// When the receiver stalls, the result holds in the output register and the
// next item stops just before its result would be written.
`default_nettype none

module scalar_kalman_position_filter import skpf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [31:0]          i_s_axis_tdata,   // [15:0] meas_x, [31:16] meas_y
    // output stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [31:0]          o_m_axis_tdata    // [15:0] filt_x, [31:16] filt_y
);

    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    logic [VAR_W-1:0] r_first_q;
    logic [VAR_W-1:0] r_steady_q;
    logic [VAR_W-1:0] r_meas_r;
    logic [VAR_W-1:0] r_start_var;
    logic [PIX_W-1:0] r_start_x;
    logic [PIX_W-1:0] r_start_y;

    t_state             r_state, n_state;
    logic               r_first_done;
    logic [CW-1:0]      r_cnt;
    logic [FRAC_BITS:0] r_gsh;
    logic [FRAC_BITS:0] r_vsh;
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    t_step_ctl          ctl;
    logic               accept;
    logic               div_start;
    logic               latch_out;
    logic [VAR_W-1:0]   q_sel;
    logic [VAR_W-1:0]   p;
    logic [VAR_W:0]     den;
    logic [FRAC_BITS:0] gain;
    logic               div_done;
    logic [PIX_W-1:0]   filt_x;
    logic [PIX_W-1:0]   filt_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_q   <= 32'd458752;
            r_steady_q  <= 32'd19661;
            r_meas_r    <= 32'd327680;
            r_start_var <= 32'd0;
            r_start_x   <= 16'd640;
            r_start_y   <= 16'd360;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_FIRST_Q:   r_first_q   <= i_cfg_wdata;
                CFG_STEADY_Q:  r_steady_q  <= i_cfg_wdata;
                CFG_MEAS_R:    r_meas_r    <= i_cfg_wdata;
                CFG_START_VAR: r_start_var <= i_cfg_wdata;
                CFG_START_X:   r_start_x   <= i_cfg_wdata[PIX_W-1:0];
                CFG_START_Y:   r_start_y   <= i_cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = i_s_axis_tvalid && (r_state == S_IDLE);
    assign q_sel  = r_first_done ? r_steady_q : r_first_q;
    assign den    = {1'b0, p} + {1'b0, r_meas_r};

    always_comb begin
        n_state    = r_state;
        ctl        = '0;
        div_start  = 1'b0;
        latch_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    ctl.load = 1'b1;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                ctl.prep  = 1'b1;
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                ctl.step = 1'b1;
                if (r_cnt == CW'(FRAC_BITS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                ctl.commit = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    latch_out = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_first_done <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state <= n_state;
            if (ctl.commit) begin
                r_first_done <= 1'b1;
            end
            if (latch_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DIV) begin
                r_cnt <= '0;
            end else if (ctl.step) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_gsh <= gain;
            r_vsh <= ONE_FX - gain;
        end else if (ctl.step) begin
            // feed multiplier bits MSB first
            r_gsh <= {r_gsh[FRAC_BITS-1:0], 1'b0};
            r_vsh <= {r_vsh[FRAC_BITS-1:0], 1'b0};
        end
        if (latch_out) begin
            r_out_data <= {filt_y, filt_x};
        end
    end

    skpf_var #(.FRAC_BITS(FRAC_BITS)) u_var (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_first_done (r_first_done),
        .i_start_var  (r_start_var),
        .i_q          (q_sel),
        .i_mul_bit    (r_vsh[FRAC_BITS]),
        .o_p          (p)
    );

    skpf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (p),
        .i_den   (den),
        .o_gain  (gain),
        .o_done  (div_done)
    );

    // the lanes take the measurement straight from the accepted beat
    skpf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_first_done (r_first_done),
        .i_start      (r_start_x),
        .i_meas       (i_s_axis_tdata[15:0]),
        .i_gain_bit   (r_gsh[FRAC_BITS]),
        .o_filt       (filt_x)
    );

    skpf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_first_done (r_first_done),
        .i_start      (r_start_y),
        .i_meas       (i_s_axis_tdata[31:16]),
        .i_gain_bit   (r_gsh[FRAC_BITS]),
        .o_filt       (filt_y)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* sv/skpf_div.sv */
// Restoring divider for the gain p * 2^F / (p + r), one quotient bit per cycle.
`default_nettype none

module skpf_div import skpf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [VAR_W-1:0]     i_num,
    input  wire logic [VAR_W:0]       i_den,
    output logic      [FRAC_BITS:0]   o_gain,
    output logic                      o_done
);

    localparam int RW = VAR_W + 2;
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [RW-1:0]      r_rem;
    logic [VAR_W:0]     r_den;
    logic [FRAC_BITS:0] r_q;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;

    logic               ge;
    logic [RW-1:0]      rem_sub;
    logic [RW-1:0]      rem_next;

    always_comb begin
        ge       = r_rem >= {1'b0, r_den};
        rem_sub  = r_rem - {1'b0, r_den};
        rem_next = ge ? rem_sub : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(FRAC_BITS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_num};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {rem_next[RW-2:0], 1'b0};
            // force a zero gain when the denominator is zero
            r_q   <= {r_q[FRAC_BITS-1:0], ge & (|r_den)};
        end
    end

    assign o_gain = r_q;
    assign o_done = r_done;

endmodule

`default_nettype wire

/* sv/skpf_lane.sv */
// One coordinate lane: estimate register, serial gain multiply and update.
`default_nettype none

module skpf_lane import skpf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire t_step_ctl               i_ctl,
    input  wire logic                    i_first_done,
    input  wire logic signed [PIX_W-1:0] i_start,
    input  wire logic signed [PIX_W-1:0] i_meas,
    input  wire logic                    i_gain_bit,
    output logic signed      [PIX_W-1:0] o_filt
);

    localparam int EW = PIX_W + 1 + FRAC_BITS;
    localparam int MW = PIX_W + FRAC_BITS;
    localparam int PW = MW + FRAC_BITS + 1;
    localparam int WW = EW - FRAC_BITS;

    logic signed [EW-1:0] r_est;
    logic signed [EW-1:0] r_diff;
    logic [MW-1:0]        r_mag;
    logic                 r_neg;
    logic [PW-1:0]        r_acc;

    logic signed [EW-1:0] est_src;
    logic signed [EW-1:0] meas_fx;
    logic signed [EW-1:0] neg_diff;
    logic [MW-1:0]        corr;
    logic signed [EW-1:0] est_upd;
    logic                 round_up;
    logic [WW-1:0]        whole;

    always_comb begin
        est_src  = i_first_done ? r_est
                                : {i_start[PIX_W-1], i_start, {FRAC_BITS{1'b0}}};
        meas_fx  = {i_meas[PIX_W-1], i_meas, {FRAC_BITS{1'b0}}};
        neg_diff = -r_diff;
        corr     = r_acc[FRAC_BITS +: MW];
        est_upd  = r_neg ? r_est - $signed({1'b0, corr}) : r_est + $signed({1'b0, corr});
        // truncate toward zero: bump the floor of a negative value with a fraction
        round_up = r_est[EW-1] & (|r_est[FRAC_BITS-1:0]);
        whole    = r_est[EW-1:FRAC_BITS] + {{(WW-1){1'b0}}, round_up};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_est  <= est_src;
            r_diff <= meas_fx - est_src;
        end
        if (i_ctl.prep) begin
            r_mag <= r_diff[EW-1] ? neg_diff[MW-1:0] : r_diff[MW-1:0];
            r_neg <= r_diff[EW-1];
            r_acc <= '0;
        end
        if (i_ctl.step) begin
            r_acc <= {r_acc[PW-2:0], 1'b0} + (i_gain_bit ? PW'(r_mag) : PW'(0));
        end
        if (i_ctl.commit) begin
            r_est <= est_upd;
        end
    end

    assign o_filt = whole[PIX_W-1:0];

endmodule

`default_nettype wire

/* sv/skpf_var.sv */
// Shared error variance: predict with process noise, then scale by (1 - gain).
`default_nettype none

module skpf_var import skpf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire t_step_ctl        i_ctl,
    input  wire logic             i_first_done,
    input  wire logic [VAR_W-1:0] i_start_var,
    input  wire logic [VAR_W-1:0] i_q,
    input  wire logic             i_mul_bit,
    output logic      [VAR_W-1:0] o_p
);

    localparam int AW = VAR_W + FRAC_BITS + 1;

    logic [VAR_W-1:0] r_var;
    logic [VAR_W-1:0] r_p;
    logic [AW-1:0]    r_acc;

    logic [VAR_W-1:0] var_src;
    logic [VAR_W:0]   p_sum;

    always_comb begin
        var_src = i_first_done ? r_var : i_start_var;
        p_sum   = {1'b0, var_src} + {1'b0, i_q};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            // saturate the predicted variance
            r_p <= p_sum[VAR_W] ? {VAR_W{1'b1}} : p_sum[VAR_W-1:0];
        end
        if (i_ctl.prep) begin
            r_acc <= '0;
        end
        if (i_ctl.step) begin
            r_acc <= {r_acc[AW-2:0], 1'b0} + (i_mul_bit ? AW'(r_p) : AW'(0));
        end
        if (i_ctl.commit) begin
            r_var <= r_acc[FRAC_BITS +: VAR_W];
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire
